// File: rtl/tim8_pkg.sv
`timescale 1ns / 1ps

package tim8_pkg;

    // Tile geometry is fixed by the packed store layout.
    localparam int TILE_SIDE = 8;

    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_MAX_DEPTH = 64;
    localparam int DEF_MAX_COLS  = 64;

    localparam int OFFSET_W = 12;
    localparam int VALUE_W  = 32;
    localparam int ELEM_W   = 8;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        KIND_WRITE_A = 3'd0,
        KIND_WRITE_B = 3'd1,
        KIND_WRITE_C = 3'd2,
        KIND_COMPUTE = 3'd3,
        KIND_READ_C  = 3'd4,
        KIND_CLEAR_C = 3'd5
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_TILE_PAIRS     = 4'd0,
        CFG_DEPTH_TILES        = 4'd1,
        CFG_COL_TILE_PAIRS     = 4'd2,
        CFG_B_TILES_TRANSPOSED = 4'd3
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]                kind;
        logic [OFFSET_W-1:0]       offset;
        logic signed [VALUE_W-1:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0]       read_offset;
        logic signed [VALUE_W-1:0] read_value;
    } out_item_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic operand_valid;
        logic acc_load;
    } mac_ctrl_t;

endpackage

// File: rtl/tiled_int8_matmul_accumulate_top.sv
`timescale 1ns / 1ps

// Channel   Ports                          Direction  Carries
// s_        s_valid, s_ready, s_data       in         command item (in_item_t)
// m_        m_valid, m_ready, m_data       out        read result item (out_item_t)
// cfg_      cfg_valid, cfg_ready, cfg_*    in         register write (index, data)
//
// A write item is done when it is accepted. A read item's value is read from the C
// store into a register and then registered on m_; the item waits in the read state
// only while an earlier result is still held there.
// A clear item zeroes all MAX_ROWS * MAX_COLS C entries, one C entry written per cycle.
// A compute item is paced by the single multiply-accumulate unit and one read port
// per store.
// Reset is synchronous and active low; the stores are not cleared by reset.

module tiled_int8_matmul_accumulate_top import tim8_pkg::*; #(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int MAX_COLS  = DEF_MAX_COLS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int A_SIZE = MAX_ROWS * MAX_DEPTH;
    localparam int B_SIZE = MAX_DEPTH * MAX_COLS;
    localparam int C_SIZE = MAX_ROWS * MAX_COLS;
    localparam int AAW    = $clog2(A_SIZE);
    localparam int BAW    = $clog2(B_SIZE);
    localparam int CAW    = $clog2(C_SIZE);
    localparam int MaxRowPairs   = MAX_ROWS / (2 * TILE_SIDE);
    localparam int MaxDepthTiles = MAX_DEPTH / TILE_SIDE;
    localparam int MaxColPairs   = MAX_COLS / (2 * TILE_SIDE);

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CLEAR = 6'b000100,
        S_LOAD  = 6'b001000,
        S_MAC   = 6'b010000,
        S_DRAIN = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [2:0] row_pairs_reg;
    logic [3:0] depth_tiles_reg;
    logic [2:0] col_pairs_reg;
    logic       b_trans_reg;

    // Sequencer counters and bases.
    logic [3:0]     zt_reg, zt_next;
    logic [3:0]     jt_reg, jt_next;
    logic [3:0]     i_reg, i_next;
    logic [2:0]     kk_reg, kk_next;
    logic [CAW-1:0] ci_reg, ci_next;
    logic [AAW-1:0] a_base_reg, a_base_next;
    logic [BAW-1:0] b_base_reg, b_base_next;
    logic [CAW-1:0] clr_cnt_reg, clr_cnt_next;
    logic           rd_v_reg, rd_v_next;
    logic           load_v_reg, load_v_next;

    // Read item bookkeeping and output register.
    logic [OFFSET_W-1:0] rd_off_reg, rd_off_next;
    logic                rd_oob_reg, rd_oob_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    // Clamped sizes.
    logic [2:0] row_pairs_eff, col_pairs_eff;
    logic [3:0] tk_eff, tr_eff, tc_eff;
    logic [9:0] tk_stride;

    // Memory ports.
    logic                     a_we, b_we, c_we, c_rd_en;
    logic [AAW-1:0]           a_wr_addr, a_rd_addr;
    logic [BAW-1:0]           b_wr_addr, b_rd_addr;
    logic [CAW-1:0]           c_wr_addr, c_rd_addr;
    logic [VALUE_W-1:0]       c_wr_data;
    logic signed [ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic [VALUE_W-1:0]       c_rd_reg;

    logic [ELEM_W-1:0]  a_mem [A_SIZE];
    logic [ELEM_W-1:0]  b_mem [B_SIZE];
    logic [VALUE_W-1:0] c_mem [C_SIZE];

    logic [31:0]   off_ext;
    logic          s_fire;
    logic [5:0]    b_inner;
    logic [31:0]   a_sum, b_sum;
    mac_ctrl_t     mac_ctrl;
    logic [VALUE_W-1:0] mac_acc;
    logic          mac_busy;
    logic          out_load;
    logic          drain_done;

    assign s_fire    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign off_ext   = {{(32-OFFSET_W){1'b0}}, s_data.offset};

    // A size of zero acts as one; a size beyond the stores saturates.
    always_comb begin
        if (row_pairs_reg == 3'd0) begin
            row_pairs_eff = 3'd1;
        end else if (32'(row_pairs_reg) > MaxRowPairs) begin
            row_pairs_eff = 3'(MaxRowPairs);
        end else begin
            row_pairs_eff = row_pairs_reg;
        end
        if (col_pairs_reg == 3'd0) begin
            col_pairs_eff = 3'd1;
        end else if (32'(col_pairs_reg) > MaxColPairs) begin
            col_pairs_eff = 3'(MaxColPairs);
        end else begin
            col_pairs_eff = col_pairs_reg;
        end
        if (depth_tiles_reg == 4'd0) begin
            tk_eff = 4'd1;
        end else if (32'(depth_tiles_reg) > MaxDepthTiles) begin
            tk_eff = 4'(MaxDepthTiles);
        end else begin
            tk_eff = depth_tiles_reg;
        end
    end

    assign tr_eff    = {row_pairs_eff, 1'b0};
    assign tc_eff    = {col_pairs_eff, 1'b0};
    assign tk_stride = {tk_eff, 6'b000000};

    // Operand addresses. The row of the current C element is ci[5:3] and its
    // column ci[2:0], since C tiles are walked in storage order.
    assign b_inner   = b_trans_reg ? {ci_reg[2:0], kk_reg} : {kk_reg, ci_reg[2:0]};
    assign a_sum     = 32'(a_base_reg) + {22'd0, i_reg, ci_reg[5:3], kk_reg};
    assign b_sum     = 32'(b_base_reg) + {22'd0, i_reg, b_inner};
    assign a_rd_addr = a_sum[AAW-1:0];
    assign b_rd_addr = b_sum[BAW-1:0];

    assign drain_done = (state_reg == S_DRAIN) && !rd_v_reg && !load_v_reg && !mac_busy;
    assign out_load   = (state_reg == S_READ) && (!m_valid_reg || m_ready);

    // Store write and read port selection.
    always_comb begin
        a_we      = s_fire && (s_data.kind == KIND_WRITE_A) && (off_ext < A_SIZE);
        b_we      = s_fire && (s_data.kind == KIND_WRITE_B) && (off_ext < B_SIZE);
        a_wr_addr = off_ext[AAW-1:0];
        b_wr_addr = off_ext[BAW-1:0];
        c_we      = 1'b0;
        c_wr_addr = off_ext[CAW-1:0];
        c_wr_data = s_data.operand_value;
        if (s_fire && (s_data.kind == KIND_WRITE_C) && (off_ext < C_SIZE)) begin
            c_we = 1'b1;
        end else if (state_reg == S_CLEAR) begin
            c_we      = 1'b1;
            c_wr_addr = clr_cnt_reg;
            c_wr_data = '0;
        end else if (drain_done) begin
            c_we      = 1'b1;
            c_wr_addr = ci_reg;
            c_wr_data = mac_acc;
        end
        c_rd_en   = 1'b0;
        c_rd_addr = off_ext[CAW-1:0];
        if (s_fire && (s_data.kind == KIND_READ_C)) begin
            c_rd_en = 1'b1;
        end else if (state_reg == S_LOAD) begin
            c_rd_en   = 1'b1;
            c_rd_addr = ci_reg;
        end
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        zt_next      = zt_reg;
        jt_next      = jt_reg;
        i_next       = i_reg;
        kk_next      = kk_reg;
        ci_next      = ci_reg;
        a_base_next  = a_base_reg;
        b_base_next  = b_base_reg;
        clr_cnt_next = clr_cnt_reg;
        rd_v_next    = 1'b0;
        load_v_next  = 1'b0;
        rd_off_next  = rd_off_reg;
        rd_oob_next  = rd_oob_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_data.kind)
                        KIND_READ_C: begin
                            rd_off_next = s_data.offset;
                            rd_oob_next = !(off_ext < C_SIZE);
                            state_next  = S_READ;
                        end
                        KIND_CLEAR_C: begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        KIND_COMPUTE: begin
                            zt_next     = '0;
                            jt_next     = '0;
                            ci_next     = '0;
                            a_base_next = '0;
                            b_base_next = '0;
                            state_next  = S_LOAD;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CAW'(1);
                if (32'(clr_cnt_reg) == C_SIZE - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD: begin
                i_next      = '0;
                kk_next     = '0;
                load_v_next = 1'b1;
                state_next  = S_MAC;
            end
            S_MAC: begin
                rd_v_next = 1'b1;
                kk_next   = kk_reg + 3'd1;
                if (kk_reg == 3'd7) begin
                    i_next = i_reg + 4'd1;
                    if (i_reg == tk_eff - 4'd1) begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (drain_done) begin
                    ci_next    = ci_reg + CAW'(1);
                    state_next = S_LOAD;
                    if (ci_reg[5:0] == 6'h3f) begin
                        if (jt_reg == tc_eff - 4'd1) begin
                            jt_next     = '0;
                            b_base_next = '0;
                            if (zt_reg == tr_eff - 4'd1) begin
                                state_next = S_IDLE;
                            end else begin
                                zt_next     = zt_reg + 4'd1;
                                a_base_next = a_base_reg + AAW'(tk_stride);
                            end
                        end else begin
                            jt_next     = jt_reg + 4'd1;
                            b_base_next = b_base_reg + BAW'(tk_stride);
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: a finished read waits here while new items are taken.
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next            = 1'b1;
            m_data_next.read_offset = rd_off_reg;
            m_data_next.read_value  = rd_oob_reg ? '0 : c_rd_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign mac_ctrl.operand_valid = rd_v_reg;
    assign mac_ctrl.acc_load      = load_v_reg;

    tim8_mac_unit u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .a_elem   (a_rd_reg),
        .b_elem   (b_rd_reg),
        .acc_init (c_rd_reg),
        .acc      (mac_acc),
        .busy     (mac_busy)
    );

    // Stores.
    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_wr_addr] <= s_data.operand_value[ELEM_W-1:0];
        end
        a_rd_reg <= a_mem[a_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[b_wr_addr] <= s_data.operand_value[ELEM_W-1:0];
        end
        b_rd_reg <= b_mem[b_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (c_we) begin
            c_mem[c_wr_addr] <= c_wr_data;
        end
        if (c_rd_en) begin
            c_rd_reg <= c_mem[c_rd_addr];
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            row_pairs_reg   <= 3'd4;
            depth_tiles_reg <= 4'd4;
            col_pairs_reg   <= 3'd4;
            b_trans_reg     <= 1'b0;
            zt_reg          <= '0;
            jt_reg          <= '0;
            i_reg           <= '0;
            kk_reg          <= '0;
            ci_reg          <= '0;
            a_base_reg      <= '0;
            b_base_reg      <= '0;
            clr_cnt_reg     <= '0;
            rd_v_reg        <= 1'b0;
            load_v_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            zt_reg      <= zt_next;
            jt_reg      <= jt_next;
            i_reg       <= i_next;
            kk_reg      <= kk_next;
            ci_reg      <= ci_next;
            a_base_reg  <= a_base_next;
            b_base_reg  <= b_base_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_v_reg    <= rd_v_next;
            load_v_reg  <= load_v_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROW_TILE_PAIRS:     row_pairs_reg   <= cfg_data[2:0];
                    CFG_DEPTH_TILES:        depth_tiles_reg <= cfg_data[3:0];
                    CFG_COL_TILE_PAIRS:     col_pairs_reg   <= cfg_data[2:0];
                    CFG_B_TILES_TRANSPOSED: b_trans_reg     <= cfg_data[0];
                    default: begin
                        b_trans_reg <= b_trans_reg;
                    end
                endcase
            end
        end
        rd_off_reg <= rd_off_next;
        rd_oob_reg <= rd_oob_next;
        m_data_reg <= m_data_next;
    end

endmodule

// File: rtl/tim8_mac_unit.sv
`timescale 1ns / 1ps

module tim8_mac_unit import tim8_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_ctrl_t                ctrl,
    input  logic signed [ELEM_W-1:0] a_elem,
    input  logic signed [ELEM_W-1:0] b_elem,
    input  logic [VALUE_W-1:0]       acc_init,
    output logic [VALUE_W-1:0]       acc,
    output logic                     busy
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_v_reg;
    logic [VALUE_W-1:0]       acc_reg;
    logic [VALUE_W-1:0]       acc_next;

    assign prod_next = a_elem * b_elem;

    // The accumulator wraps at 32 bits; products are sign-extended.
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.acc_load) begin
            acc_next = acc_init;
        end else if (prod_v_reg) begin
            acc_next = acc_reg + {{(VALUE_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_v_reg <= 1'b0;
        end else begin
            prod_v_reg <= ctrl.operand_valid;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_v_reg;

endmodule

// File: sim/tb_tiled_int8_matmul_accumulate_top.sv
`timescale 1ns / 1ps

module tb_tiled_int8_matmul_accumulate_top;
    import tim8_pkg::*;

    localparam int A_DEPTH        = DEF_MAX_ROWS * DEF_MAX_DEPTH;
    localparam int B_DEPTH        = DEF_MAX_DEPTH * DEF_MAX_COLS;
    localparam int C_DEPTH        = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int TILE_AREA      = TILE_SIDE * TILE_SIDE;
    localparam int ROW_PAIR_MAX   = DEF_MAX_ROWS / (2 * TILE_SIDE);
    localparam int DEPTH_TILE_MAX = DEF_MAX_DEPTH / TILE_SIDE;
    localparam int COL_PAIR_MAX   = DEF_MAX_COLS / (2 * TILE_SIDE);
    localparam logic [OFFSET_W-1:0] OFFSET_TOP = '1;

    // Kinds and register indexes that the block must ignore.
    localparam logic [2:0]           KIND_SPARE_6 = 3'd6;
    localparam logic [2:0]           KIND_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

    localparam int WATCHDOG_LIMIT  = 1500000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 48;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Mirror of the three element stores and of the geometry registers.
    logic signed [ELEM_W-1:0] a_mirror [A_DEPTH];
    logic signed [ELEM_W-1:0] b_mirror [B_DEPTH];
    logic [VALUE_W-1:0]       c_mirror [C_DEPTH];
    bit                       a_loaded [A_DEPTH];
    bit                       b_loaded [B_DEPTH];
    logic [2:0]               row_pairs_q    = 3'd4;
    logic [3:0]               depth_q        = 4'd4;
    logic [2:0]               col_pairs_q    = 3'd4;
    logic                     b_transposed_q = 1'b0;

    out_item_t pending_reads [$];
    out_item_t expected_read;
    int        mismatches    = 0;
    int        cycle_count   = 0;
    int        busy_deadline = 0;
    int        quiet_cycles  = 0;
    bit        gaps_on       = 1'b1;

    tiled_int8_matmul_accumulate_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int fit_count(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int row_tiles();
        return 2 * fit_count(row_pairs_q, ROW_PAIR_MAX);
    endfunction

    function automatic int depth_count();
        return fit_count(depth_q, DEPTH_TILE_MAX);
    endfunction

    function automatic int col_tiles();
        return 2 * fit_count(col_pairs_q, COL_PAIR_MAX);
    endfunction

    // C += A x B over the configured tile region, wrapping at 32 bits.
    function automatic void accumulate_tile_product();
        int                 tr;
        int                 tk;
        int                 tc;
        int                 ci;
        int                 ai;
        int                 bi;
        int                 prod;
        logic [VALUE_W-1:0] acc;
        tr = row_tiles();
        tk = depth_count();
        tc = col_tiles();
        for (int zt = 0; zt < tr; zt++)
            for (int jt = 0; jt < tc; jt++)
                for (int r = 0; r < TILE_SIDE; r++)
                    for (int c = 0; c < TILE_SIDE; c++) begin
                        ci  = (zt * tc + jt) * TILE_AREA + r * TILE_SIDE + c;
                        acc = c_mirror[ci];
                        for (int i = 0; i < tk; i++)
                            for (int kk = 0; kk < TILE_SIDE; kk++) begin
                                ai = (zt * tk + i) * TILE_AREA + r * TILE_SIDE + kk;
                                bi = (jt * tk + i) * TILE_AREA +
                                     (b_transposed_q ? c * TILE_SIDE + kk : kk * TILE_SIDE + c);
                                prod = int'(a_mirror[ai]) * int'(b_mirror[bi]);
                                acc  = acc + VALUE_W'(prod);
                            end
                        c_mirror[ci] = acc;
                    end
    endfunction

    function automatic void predict_command(input in_item_t item);
        out_item_t reply;
        case (item.kind)
            KIND_WRITE_A: begin
                a_mirror[item.offset] = item.operand_value[ELEM_W-1:0];
                a_loaded[item.offset] = 1'b1;
            end
            KIND_WRITE_B: begin
                b_mirror[item.offset] = item.operand_value[ELEM_W-1:0];
                b_loaded[item.offset] = 1'b1;
            end
            KIND_WRITE_C: c_mirror[item.offset] = item.operand_value;
            KIND_COMPUTE: accumulate_tile_product();
            KIND_READ_C: begin
                reply.read_offset = item.offset;
                reply.read_value  = c_mirror[item.offset];
                pending_reads.push_back(reply);
            end
            KIND_CLEAR_C: foreach (c_mirror[i]) c_mirror[i] = '0;
            default: ;
        endcase
    endfunction

    function automatic int item_latency(input logic [2:0] kind);
        case (kind)
            KIND_COMPUTE: return row_tiles() * col_tiles() * TILE_AREA *
                                 (depth_count() * TILE_SIDE + 4) + 1;
            KIND_CLEAR_C: return C_DEPTH + 1;
            default:      return 4;
        endcase
    endfunction

    // Valid is left high after acceptance so the next item can follow back to back;
    // any caller that lets time pass without sending lowers it first.
    task automatic send_command(input logic [2:0] kind, input logic [OFFSET_W-1:0] offset,
                                input logic [VALUE_W-1:0] value);
        in_item_t item;
        item.kind          = kind;
        item.offset        = offset;
        item.operand_value = value;
        while (gaps_on && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        busy_deadline = ((busy_deadline > cycle_count) ? busy_deadline : cycle_count) +
                        item_latency(kind);
        predict_command(item);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reads.size() != 0 || cycle_count < busy_deadline + 8);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW_TILE_PAIRS:     row_pairs_q    = value[2:0];
            CFG_DEPTH_TILES:        depth_q        = value[3:0];
            CFG_COL_TILE_PAIRS:     col_pairs_q    = value[2:0];
            CFG_B_TILES_TRANSPOSED: b_transposed_q = value[0];
            default: ;
        endcase
    endtask

    // Upper data bits are random and must be dropped by the register.
    task automatic apply_geometry(input int row, input int depth, input int col, input int trans);
        write_register(CFG_ROW_TILE_PAIRS, (32'($urandom) << 3) | 32'(row));
        write_register(CFG_DEPTH_TILES, (32'($urandom) << 4) | 32'(depth));
        write_register(CFG_COL_TILE_PAIRS, (32'($urandom) << 3) | 32'(col));
        write_register(CFG_B_TILES_TRANSPOSED, (32'($urandom) << 1) | 32'(trans));
    endtask

    // Every A and B entry that a compute will touch must hold a value first.
    task automatic prime_operands();
        int a_span;
        int b_span;
        a_span = row_tiles() * depth_count() * TILE_AREA;
        b_span = col_tiles() * depth_count() * TILE_AREA;
        for (int i = 0; i < a_span; i++)
            if (!a_loaded[i]) send_command(KIND_WRITE_A, OFFSET_W'(i), $urandom());
        for (int i = 0; i < b_span; i++)
            if (!b_loaded[i]) send_command(KIND_WRITE_B, OFFSET_W'(i), $urandom());
    endtask

    task automatic run_tile_product(input int samples);
        int c_span;
        prime_operands();
        c_span = row_tiles() * col_tiles() * TILE_AREA;
        send_command(KIND_COMPUTE, OFFSET_W'($urandom()), $urandom());
        send_command(KIND_READ_C, OFFSET_W'(c_span - 1), $urandom());
        send_command(KIND_READ_C, '0, $urandom());
        repeat (samples)
            send_command(KIND_READ_C, OFFSET_W'($urandom_range(c_span - 1)), $urandom());
    endtask

    function automatic logic [OFFSET_W-1:0] aim_offset(input int span);
        return ($urandom_range(3) != 0) ? OFFSET_W'($urandom_range(span - 1)) :
                                          OFFSET_W'($urandom_range(OFFSET_TOP));
    endfunction

    task automatic issue_random_command();
        int                 pick;
        logic [VALUE_W-1:0] value;
        pick  = $urandom_range(99);
        value = $urandom();
        if ($urandom_range(7) == 0) value[7:0] = $urandom_range(1) ? 8'h80 : 8'h7F;
        if (pick < 22)
            send_command(KIND_WRITE_A, aim_offset(row_tiles() * depth_count() * TILE_AREA), value);
        else if (pick < 44)
            send_command(KIND_WRITE_B, aim_offset(col_tiles() * depth_count() * TILE_AREA), value);
        else if (pick < 52)
            send_command(KIND_WRITE_C, aim_offset(row_tiles() * col_tiles() * TILE_AREA), value);
        else if (pick < 84)
            send_command(KIND_READ_C, aim_offset(row_tiles() * col_tiles() * TILE_AREA), value);
        else if (pick < 86)
            send_command(KIND_COMPUTE, OFFSET_W'($urandom()), value);
        else if (pick < 87)
            send_command(KIND_CLEAR_C, OFFSET_W'($urandom()), value);
        else if (pick < 90)
            send_command($urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7,
                         OFFSET_W'($urandom()), value);
        else
            send_command(KIND_READ_C, OFFSET_W'($urandom()), value);
    endtask

    // Single element access, field extremes and the ignored kinds.
    task automatic test_store_access();
        send_command(KIND_CLEAR_C, '0, $urandom());
        send_command(KIND_READ_C, '0, $urandom());
        send_command(KIND_READ_C, OFFSET_TOP, $urandom());
        send_command(KIND_WRITE_C, '0, 32'h8000_0000);
        send_command(KIND_WRITE_C, OFFSET_TOP, 32'h7FFF_FFFF);
        send_command(KIND_WRITE_C, 12'hAAA, 32'hFFFF_FFFF);
        send_command(KIND_READ_C, '0, $urandom());
        send_command(KIND_READ_C, OFFSET_TOP, $urandom());
        send_command(KIND_READ_C, 12'hAAA, $urandom());
        send_command(KIND_WRITE_A, '0, 32'hFFFF_FF80);
        send_command(KIND_WRITE_A, OFFSET_TOP, 32'h1234_567F);
        send_command(KIND_WRITE_B, '0, 32'h0000_0080);
        send_command(KIND_WRITE_B, OFFSET_TOP, 32'hFFFF_FF7F);
        send_command(KIND_SPARE_6, '0, $urandom());
        send_command(KIND_SPARE_7, OFFSET_TOP, $urandom());
        send_command(KIND_READ_C, '0, $urandom());
        send_command(KIND_READ_C, OFFSET_TOP, $urandom());
        send_command(KIND_CLEAR_C, OFFSET_TOP, $urandom());
        send_command(KIND_READ_C, 12'hAAA, $urandom());
        send_command(KIND_READ_C, 12'h555, $urandom());
    endtask

    // The row and column counts and the B layout left by reset. Only the depth is
    // narrowed so that loading the operands stays short; this run has no idling.
    task automatic test_reset_geometry();
        gaps_on = 1'b0;
        write_register(CFG_DEPTH_TILES, 32'd1);
        run_tile_product(48);
        gaps_on = 1'b1;
    endtask

    // Size registers at zero and beyond the top of rows and columns, both B tile
    // layouts, and unused indexes.
    task automatic test_register_extremes();
        apply_geometry(0, 0, 0, 1);
        write_register(CFG_SPARE_LO, $urandom());
        write_register(CFG_SPARE_HI, $urandom());
        run_tile_product(12);
        apply_geometry(7, 1, 1, 0);
        run_tile_product(12);
        apply_geometry(2, 2, 2, 1);
        run_tile_product(12);
        apply_geometry(1, 2, 1, 0);
        run_tile_product(12);
        apply_geometry(1, 1, 7, 1);
        run_tile_product(12);
    endtask

    // Mixed traffic under random small geometries; the first phase runs without gaps.
    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            gaps_on = (p != 0);
            apply_geometry($urandom_range(2), $urandom_range(2), $urandom_range(2),
                           $urandom_range(1));
            prime_operands();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) issue_random_command();
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        m_ready <= gaps_on ? ($urandom_range(99) >= 33) : 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected read result, actual offset %0d value %0d",
                         $time, m_data.read_offset, m_data.read_value);
                mismatches++;
            end else begin
                expected_read = pending_reads.pop_front();
                if (m_data.read_offset !== expected_read.read_offset) begin
                    $display("%0t: read_offset expected %0d actual %0d", $time,
                             expected_read.read_offset, m_data.read_offset);
                    mismatches++;
                end
                if (m_data.read_value !== expected_read.read_value) begin
                    $display("%0t: read_value at offset %0d expected %0d actual %0d", $time,
                             expected_read.read_offset, expected_read.read_value,
                             m_data.read_value);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tiled_int8_matmul_accumulate_top regression: fail");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_store_access();
        test_reset_geometry();
        test_register_extremes();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0)
            $display("tiled_int8_matmul_accumulate_top regression: pass");
        else
            $display("tiled_int8_matmul_accumulate_top regression: fail");
        $finish;
    end

endmodule
